### hdl/fqk_pkg.sv
// shared types and constants for the keyed-removal fifo
package fqk_pkg;

	localparam int KEY_W         = 32;
	localparam int PAY_W         = 32;
	localparam int FILL_W        = 5;
	localparam int DEPTH_DEFAULT = 16;

	// operation codes of a request
	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_DELETE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_PRI,
		FSM_COMMIT
	} fsm_t;

	typedef struct packed {
		op_t               opcode;
		logic [KEY_W-1:0]  entry_key;
		logic [PAY_W-1:0]  entry_payload;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [KEY_W-1:0]  found_key;
		logic [PAY_W-1:0]  found_payload;
		logic [FILL_W-1:0] fill_count;
		logic              is_empty;
	} rsp_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic cmp_en;    // register the match flag this cycle
		logic occupied;  // cell may report a hit
		logic take_head; // hit on occupancy alone (get)
		logic load;      // store the new entry
		logic shift;     // take the entry of the next cell
	} cell_ctrl_t;

endpackage

### hdl/fqk_cell.sv
// one slot of the queue: entry storage, key compare and neighbor shift
module fqk_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fqk_pkg::cell_ctrl_t     ctrl,
	input  logic [fqk_pkg::KEY_W-1:0] cmp_key,
	input  logic [fqk_pkg::KEY_W-1:0] new_key,
	input  logic [fqk_pkg::PAY_W-1:0] new_pay,
	input  logic [fqk_pkg::KEY_W-1:0] nbr_key,
	input  logic [fqk_pkg::PAY_W-1:0] nbr_pay,
	output logic [fqk_pkg::KEY_W-1:0] key,
	output logic [fqk_pkg::PAY_W-1:0] pay,
	output logic                    hit
);
	import fqk_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             hit_q;
	logic             hit_d;

	// match against the request key, or plain occupancy for a head removal
	assign hit_d = ctrl.occupied && (ctrl.take_head || (key_q == cmp_key));

	// match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			hit_q <= hit_d;
		end
	end

	// entry storage: load at the tail or shift toward the head
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= new_key;
			pay_q <= new_pay;
		end else if (ctrl.shift) begin
			key_q <= nbr_key;
			pay_q <= nbr_pay;
		end
	end

	assign key = key_q;
	assign pay = pay_q;
	assign hit = hit_q;

endmodule

### hdl/fifo_with_keyed_removal_unit.sv
// top level of the keyed-removal fifo: sequencer, cell row and result register
//
// Ordered queue of up to DEPTH entries (key and payload), held in a row of
// cells with the head in cell 0. A request is put, get, delete by key or
// search by key, and each gives exactly one response with status, the
// entry removed or found (zero when none), the fill count and an empty flag.
// A request passes these steps between acceptance and response: one to take
// it, one where all cells compare their keys in parallel, one to pick the
// oldest match and the cells at or behind it, and one where the row shifts
// or loads and the response register is written. The sequencer holds one
// request at a time; the response register lets the next request be taken
// while a response still waits, and the final step stalls only while that
// register is full and not being drained. No clearing pass is needed after
// reset: only cells below the fill count are ever looked at.
module fifo_with_keyed_removal_unit #(
	parameter int DEPTH = fqk_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fqk_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fqk_pkg::rsp_t rsp
);
	import fqk_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVL   = $clog2(DEPTH);

	fsm_t             state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CNT_W-1:0] count_q;
	logic [DEPTH-1:0] first_q;
	logic [DEPTH-1:0] pre_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             req_go;
	logic             cmp_go;
	logic             pri_go;
	logic             commit_go;

	cell_ctrl_t       ctrl   [DEPTH];
	logic [KEY_W-1:0] c_key  [DEPTH];
	logic [PAY_W-1:0] c_pay  [DEPTH];
	logic [DEPTH-1:0] hit;

	logic [DEPTH-1:0] prefix;
	logic             found;
	logic [KEY_W-1:0] sel_key;
	logic [PAY_W-1:0] sel_pay;
	logic             do_load;
	logic             do_shift;
	logic             cnt_inc;
	logic             cnt_dec;
	status_t          stat;
	logic [CNT_W-1:0] count_nx;
	logic [31:0]      count_wide;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step strobes
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmp_go    = 1'b0;
		pri_go    = 1'b0;
		commit_go = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = FSM_CMP;
				end
			end
			FSM_CMP: begin
				cmp_go  = 1'b1;
				state_d = FSM_PRI;
			end
			FSM_PRI: begin
				pri_go  = 1'b1;
				state_d = FSM_COMMIT;
			end
			FSM_COMMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					commit_go = 1'b1;
					state_d   = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign req_go = req_valid && req_ready;

	// request capture
	always_ff @(posedge clk) begin
		if (req_go) begin
			op_q  <= req.opcode;
			key_q <= req.entry_key;
			pay_q <= req.entry_payload;
		end
	end

	// oldest match: log-step prefix or over the registered hits
	always_comb begin
		logic [DEPTH-1:0] p;
		p = hit;
		for (int s = 0; s < LVL; s++) begin
			p = p | (p << (1 << s));
		end
		prefix = p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			pre_q   <= '0;
		end else if (pri_go) begin
			first_q <= hit & ~(prefix << 1);
			pre_q   <= prefix;
		end
	end

	// pick the entry of the matching cell
	always_comb begin
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_key = sel_key | (first_q[i] ? c_key[i] : '0);
			sel_pay = sel_pay | (first_q[i] ? c_pay[i] : '0);
		end
	end

	assign found = |first_q;

	// operation decode for the final step
	always_comb begin
		stat    = STAT_OK;
		do_load = 1'b0;
		do_shift = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		case (op_q)
			OP_PUT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					stat = STAT_FULL;
				end else begin
					do_load = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			OP_GET: begin
				if (!found) begin
					stat = STAT_EMPTY;
				end else begin
					do_shift = 1'b1;
					cnt_dec  = 1'b1;
				end
			end
			OP_DELETE: begin
				if (!found) begin
					stat = STAT_NOT_FOUND;
				end else begin
					do_shift = 1'b1;
					cnt_dec  = 1'b1;
				end
			end
			OP_SEARCH: begin
				if (!found) begin
					stat = STAT_NOT_FOUND;
				end
			end
			default: begin
				stat = STAT_OK;
			end
		endcase
	end

	always_comb begin
		count_nx = count_q;
		if (cnt_inc) begin
			count_nx = count_q + CNT_W'(1);
		end else if (cnt_dec) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	assign count_wide = 32'(count_nx);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit_go) begin
			count_q <= count_nx;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			rsp_q.status        <= stat;
			rsp_q.found_key     <= sel_key;
			rsp_q.found_payload <= sel_pay;
			rsp_q.fill_count    <= count_wide[FILL_W-1:0];
			rsp_q.is_empty      <= (count_nx == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nbr_key;
		logic [PAY_W-1:0] nbr_pay;

		always_comb begin
			ctrl[i].cmp_en    = cmp_go;
			ctrl[i].occupied  = (CNT_W'(i) < count_q) && (op_q != OP_PUT)
			                    && ((op_q != OP_GET) || (i == 0));
			ctrl[i].take_head = (op_q == OP_GET);
			ctrl[i].load      = commit_go && do_load && (CNT_W'(i) == count_q);
			ctrl[i].shift     = commit_go && do_shift && pre_q[i];
		end

		if (i == DEPTH - 1) begin : g_last
			assign nbr_key = '0;
			assign nbr_pay = '0;
		end else begin : g_mid
			assign nbr_key = c_key[i+1];
			assign nbr_pay = c_pay[i+1];
		end

		fqk_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl[i]),
			.cmp_key (key_q),
			.new_key (key_q),
			.new_pay (pay_q),
			.nbr_key (nbr_key),
			.nbr_pay (nbr_pay),
			.key     (c_key[i]),
			.pay     (c_pay[i]),
			.hit     (hit[i])
		);
	end

`ifndef SYNTHESIS
	// fill count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above capacity");

	// at most one cell is picked as the oldest match
	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_q))
		else $error("more than one cell picked");

	// fill count moves only in the final step
	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(commit_go))
		else $error("fill count changed outside commit");

	// an accepted request is compared in the next cycle
	a_req_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		req_go |=> state_q == FSM_CMP)
		else $error("request not followed by compare");

	// a removal always has a picked cell
	a_shift_found: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && do_shift |-> found)
		else $error("shift without a match");
`endif

endmodule

### sim/tb_fifo_with_keyed_removal_unit.sv
// testbench for the keyed-removal fifo: directed and random requests checked against a queue model
`timescale 1ns / 1ps

import fqk_pkg::*;

// queue model of the block plus the list of responses still owed
class fqk_scoreboard;
	localparam int CAPACITY   = DEPTH_DEFAULT;
	localparam int REPORT_MAX = 10;

	logic [KEY_W-1:0] held_keys[$];
	logic [PAY_W-1:0] held_pays[$];
	rsp_t             awaited[$];

	int n_checked;
	int n_bad;
	int peak_fill;
	int op_seen[4];
	int status_seen[4];

	// apply one accepted request to the model and queue its response
	function void note_request(req_t r);
		rsp_t want;
		int   hit;
		want = '0;
		want.status = STAT_OK;
		case (r.opcode)
			OP_PUT: begin
				if (held_keys.size() >= CAPACITY) begin
					want.status = STAT_FULL;
				end else begin
					held_keys.push_back(r.entry_key);
					held_pays.push_back(r.entry_payload);
				end
			end
			OP_GET: begin
				if (held_keys.size() == 0) begin
					want.status = STAT_EMPTY;
				end else begin
					want.found_key     = held_keys.pop_front();
					want.found_payload = held_pays.pop_front();
				end
			end
			default: begin
				// oldest match wins for delete and search
				hit = -1;
				for (int i = 0; i < held_keys.size(); i++) begin
					if (held_keys[i] == r.entry_key) begin
						hit = i;
						break;
					end
				end
				if (hit < 0) begin
					want.status = STAT_NOT_FOUND;
				end else begin
					want.found_key     = held_keys[hit];
					want.found_payload = held_pays[hit];
					if (r.opcode == OP_DELETE) begin
						held_keys.delete(hit);
						held_pays.delete(hit);
					end
				end
			end
		endcase
		want.fill_count = FILL_W'(held_keys.size());
		want.is_empty   = (held_keys.size() == 0);
		if (held_keys.size() > peak_fill)
			peak_fill = held_keys.size();
		op_seen[r.opcode]++;
		status_seen[want.status]++;
		awaited.push_back(want);
	endfunction

	// compare one accepted response with the oldest one owed
	function void check_response(rsp_t got);
		rsp_t want;
		if (awaited.size() == 0) begin
			n_bad++;
			if (n_bad <= REPORT_MAX)
				$display("%0t: response with nothing outstanding: status %0d key %h pay %h",
					$realtime, got.status, got.found_key, got.found_payload);
			return;
		end
		want = awaited.pop_front();
		n_checked++;
		if (got.status !== want.status || got.found_key !== want.found_key ||
				got.found_payload !== want.found_payload ||
				got.fill_count !== want.fill_count || got.is_empty !== want.is_empty) begin
			n_bad++;
			if (n_bad <= REPORT_MAX) begin
				$display("%0t: bad response %0d", $realtime, n_checked);
				$display("  expected status %0d key %h pay %h fill %0d empty %b",
					want.status, want.found_key, want.found_payload,
					want.fill_count, want.is_empty);
				$display("  actual   status %0d key %h pay %h fill %0d empty %b",
					got.status, got.found_key, got.found_payload,
					got.fill_count, got.is_empty);
			end
		end
	endfunction
endclass

module tb_fifo_with_keyed_removal_unit;

	localparam int N_RANDOM       = 500;
	localparam int RESET_CYCLES   = 6;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 16;

	typedef enum int {
		RDY_ALWAYS,
		RDY_EVERY_FOURTH,
		RDY_COIN,
		RDY_LONG_HOLD
	} ready_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	fqk_scoreboard    sb;
	logic [KEY_W-1:0] key_pool[8];
	int               idle_cycles = 0;
	int               win_pos     = 0;
	ready_mode_t      ready_mode  = RDY_ALWAYS;

	fifo_with_keyed_removal_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// present one request and hold it until the block takes it
	task automatic send_request(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	// idle the sender until every owed response has come back
	task automatic settle_queue();
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	function automatic req_t make_request(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		req_t r;
		r.opcode        = op;
		r.entry_key     = k;
		r.entry_payload = p;
		return r;
	endfunction

	// random request; keys mostly reuse held or pooled values so matches and duplicates occur
	function automatic req_t next_random_request(int put_pct);
		req_t r;
		int   roll;
		int   held;
		held = sb.held_keys.size();
		r.entry_payload = $urandom;
		roll = $urandom_range(99);
		if (roll < put_pct) begin
			r.opcode = OP_PUT;
		end else begin
			case ($urandom_range(2))
				0:       r.opcode = OP_GET;
				1:       r.opcode = OP_DELETE;
				default: r.opcode = OP_SEARCH;
			endcase
		end
		roll = $urandom_range(99);
		if (r.opcode == OP_PUT)
			r.entry_key = (roll < 60) ? key_pool[$urandom_range(7)] : $urandom;
		else if (held > 0 && roll < 65)
			r.entry_key = sb.held_keys[$urandom_range(held - 1)];
		else if (roll < 85)
			r.entry_key = key_pool[$urandom_range(7)];
		else
			r.entry_key = $urandom;
		return r;
	endfunction

	// response side: check every accepted transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	// receiver back-pressure, with a pattern drawn at random at the start of each window
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			win_pos = 0;
		end else begin
			if (win_pos == 0)
				ready_mode = ready_mode_t'($urandom_range(3));
			case (ready_mode)
				RDY_ALWAYS:       rsp_ready <= 1'b1;
				RDY_EVERY_FOURTH: rsp_ready <= (win_pos % 4) != 3;
				RDY_COIN:         rsp_ready <= 1'($urandom_range(1));
				default:          rsp_ready <= (win_pos >= 16);
			endcase
			win_pos = (win_pos + 1) % 48;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("fifo_with_keyed_removal_unit: mismatch");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int   sent;
		int   burst;
		int   gap;
		int   put_pct;
		bit   drained_once;
		req_t r;

		sb = new;
		sent = 0;
		drained_once = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: get, delete and search all fail
		send_request(make_request(OP_GET,    32'h0000_0000, 32'hFFFF_FFFF));
		send_request(make_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
		send_request(make_request(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// extreme keys and payloads, then a duplicated key
		send_request(make_request(OP_PUT,    32'h0000_0000, 32'hFFFF_FFFF));
		send_request(make_request(OP_PUT,    32'hFFFF_FFFF, 32'h0000_0000));
		send_request(make_request(OP_PUT,    32'h5A5A_0005, 32'h0000_0001));
		send_request(make_request(OP_PUT,    32'h5A5A_0005, 32'h0000_0002));
		// duplicates: search and delete hit the oldest copy
		send_request(make_request(OP_SEARCH, 32'h5A5A_0005, 32'h1234_5678));
		send_request(make_request(OP_DELETE, 32'h5A5A_0005, 32'h0000_0000));
		send_request(make_request(OP_SEARCH, 32'h5A5A_0005, 32'h0000_0000));
		send_request(make_request(OP_DELETE, 32'hA5A5_A5A5, 32'h0000_0000));
		// fill to capacity, then one put too many
		for (int i = 0; i < 13; i++)
			send_request(make_request(OP_PUT, {i[3:0], 28'hC3C_3C3C} ^ 32'h8000_0001,
				~{4'(i), 28'h0F0_F0F0}));
		send_request(make_request(OP_PUT,    32'hDEAD_BEEF, 32'hFFFF_FFFF));
		send_request(make_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000));
		send_request(make_request(OP_GET,    32'h0000_0000, 32'h0000_0000));
		req_valid <= 1'b0;
		settle_queue();

		// random bursts, swinging between filling and draining phases
		while (sent < N_RANDOM) begin
			burst = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
				put_pct = ((sent / 30) % 2 == 0) ? 70 : 25;
				r = next_random_request(put_pct);
				send_request(r);
				sent++;
			end
			gap = $urandom_range(0, 6);
			if (!drained_once && sent >= N_RANDOM / 2) begin
				drained_once = 1;
				req_valid <= 1'b0;
				settle_queue();
			end else if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		settle_queue();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d transactions: %0d put, %0d get, %0d delete, %0d search",
			sb.n_checked, sb.op_seen[OP_PUT], sb.op_seen[OP_GET],
			sb.op_seen[OP_DELETE], sb.op_seen[OP_SEARCH]);
		$display("outcomes: %0d full, %0d empty, %0d key misses, peak fill %0d",
			sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY],
			sb.status_seen[STAT_NOT_FOUND], sb.peak_fill);
		if (sb.n_bad == 0 && sb.awaited.size() == 0) begin
			$display("fifo_with_keyed_removal_unit: match");
		end else begin
			$display("%0d bad responses, %0d still owed", sb.n_bad, sb.awaited.size());
			$display("fifo_with_keyed_removal_unit: mismatch");
		end
		$finish;
	end

endmodule
